[hw/rtl/osrt_pkg.sv]
// Shared definitions for the ordered slot ring tracker.
// Command codes, status codes, sequencer states and the step-unit status bundle.
// No dependencies.
`timescale 1ns / 1ps

package osrt_pkg;

    // Default ring size
    localparam int SLOTS_DEFAULT = 16;

    // Field widths of the stream payloads
    localparam int MODE_W   = 3;
    localparam int SID_W    = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int WCNT_W   = 8;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_PUT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAKE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TAKE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OPEN    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_WAIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_CLOSED = 2'd2;

    // Writer count ceiling
    localparam logic [WCNT_W-1:0] WRITERS_MAX = 8'hFF;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_EMIT
    } t_state;

    // Status from the step unit to the sequencer
    typedef struct packed {
        logic stop;  // head walk ends at this slot
        logic sat;   // credit counter already at its ceiling
    } t_walk_stat;

endpackage

[hw/rtl/ordered_slot_ring_tracker_unit.sv]
// Top level of the ordered slot ring tracker: command stream in, one result per command out.
// Holds slot ownership/ready bits, ring heads, credit counters and the command sequencer.
// Depends on osrt_pkg and osrt_walk_unit.
`timescale 1ns / 1ps

// Each command on the slave stream yields exactly one result on the master stream. A command
// is taken only while the sequencer is idle. Put, take, open_writer, close_writer and ignored
// commands pass through the execute and emit states before the next command is taken. A
// make_available or release that hits its head walks the ring one slot per cycle through the
// shared step unit, between the execute and emit states. The walk stops at the first slot not
// yet done or at its bounding head (put_head for the ready run, take_head for the release
// run), so the head advances by at most SLOTS - 1 slots. A finished result waits in the
// output register while the next command is accepted and executed; the sequencer only stalls
// at its last step if that register is still full. Slot indexes come from a 4-bit field, so
// with SLOTS above 16 only slots 0..15 can be made available or released; granted slot and
// credit fields carry the low 4 bits of their values.
module ordered_slot_ring_tracker_unit #(
    parameter int SLOTS = osrt_pkg::SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] mode, [6:3] slot_id, [7] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] status, [5:2] granted_slot, [9:6] put_credits,
                                        // [13:10] take_credits, [14] is_closed, [15] zero
);

    localparam int IW = $clog2(SLOTS);

    // Tracker state
    logic [SLOTS-1:0]              r_owned, n_owned;
    logic [SLOTS-1:0]              r_ready, n_ready;
    logic [IW-1:0]                 r_put_head, n_put_head;
    logic [IW-1:0]                 r_ready_head, n_ready_head;
    logic [IW-1:0]                 r_take_head, n_take_head;
    logic [IW-1:0]                 r_rel_head, n_rel_head;
    logic [IW-1:0]                 r_free, n_free;
    logic [IW-1:0]                 r_rcnt, n_rcnt;
    logic                          r_closed, n_closed;
    logic [osrt_pkg::WCNT_W-1:0]   r_writers, n_writers;

    // Sequencer and command registers
    osrt_pkg::t_state              r_state, n_state;
    logic [osrt_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [osrt_pkg::SID_W-1:0]    r_sid, n_sid;
    logic [osrt_pkg::STATUS_W-1:0] r_status, n_status;
    logic [IW-1:0]                 r_granted, n_granted;
    logic [IW:0]                   r_steps, n_steps;

    // Output register
    logic                          r_out_valid, n_out_valid;
    logic [15:0]                   r_out_data, n_out_data;

    // Step unit connections
    logic [IW-1:0]                 w_head, w_limit, w_count, w_head_nx, w_count_nx;
    logic                          w_bit_ok;
    osrt_pkg::t_walk_stat          w_stat;

    logic [IW-1:0]                 sid_idx;
    logic                          sid_ok;

    assign sid_idx = IW'(r_sid);
    assign sid_ok  = (32'(r_sid) < SLOTS);

    assign s_axis_tready = (r_state == osrt_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Operand select for the shared step unit
    always_comb begin
        case (r_mode)
            osrt_pkg::MODE_PUT:  w_head = r_put_head;
            osrt_pkg::MODE_MAKE: w_head = r_ready_head;
            osrt_pkg::MODE_TAKE: w_head = r_take_head;
            default:             w_head = r_rel_head;
        endcase
        if (r_mode == osrt_pkg::MODE_MAKE) begin
            w_limit  = r_put_head;
            w_bit_ok = r_ready[r_ready_head];
            w_count  = r_rcnt;
        end else begin
            w_limit  = r_take_head;
            w_bit_ok = !r_owned[r_rel_head];
            w_count  = r_free;
        end
    end

    osrt_walk_unit #(
        .SLOTS (SLOTS)
    ) u_walk (
        .i_head     (w_head),
        .i_limit    (w_limit),
        .i_bit_ok   (w_bit_ok),
        .i_count    (w_count),
        .i_steps    (r_steps),
        .o_head_nx  (w_head_nx),
        .o_count_nx (w_count_nx),
        .o_stat     (w_stat)
    );

    // Sequencer: next state and state updates
    always_comb begin
        n_owned      = r_owned;
        n_ready      = r_ready;
        n_put_head   = r_put_head;
        n_ready_head = r_ready_head;
        n_take_head  = r_take_head;
        n_rel_head   = r_rel_head;
        n_free       = r_free;
        n_rcnt       = r_rcnt;
        n_closed     = r_closed;
        n_writers    = r_writers;
        n_state      = r_state;
        n_mode       = r_mode;
        n_sid        = r_sid;
        n_status     = r_status;
        n_granted    = r_granted;
        n_steps      = r_steps;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;

        case (r_state)
            osrt_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tdata[2:0];
                    n_sid   = s_axis_tdata[6:3];
                    n_state = osrt_pkg::ST_EXEC;
                end
            end

            osrt_pkg::ST_EXEC: begin
                n_status  = osrt_pkg::STAT_DONE;
                n_granted = '0;
                n_steps   = '0;
                n_state   = osrt_pkg::ST_EMIT;
                case (r_mode)
                    osrt_pkg::MODE_PUT: begin
                        if (r_free == '0) begin
                            n_status = osrt_pkg::STAT_WAIT;
                        end else begin
                            n_granted           = r_put_head;
                            n_owned[r_put_head] = 1'b1;
                            n_put_head          = w_head_nx;
                            n_free              = r_free - IW'(1);
                        end
                    end
                    osrt_pkg::MODE_MAKE: begin
                        if (sid_ok) begin
                            n_ready[sid_idx] = 1'b1;
                            if (r_ready_head == sid_idx) n_state = osrt_pkg::ST_WALK;
                        end
                    end
                    osrt_pkg::MODE_TAKE: begin
                        if (r_rcnt == '0) begin
                            n_status = r_closed ? osrt_pkg::STAT_CLOSED : osrt_pkg::STAT_WAIT;
                        end else begin
                            n_granted            = r_take_head;
                            n_ready[r_take_head] = 1'b0;
                            n_take_head          = w_head_nx;
                            n_rcnt               = r_rcnt - IW'(1);
                        end
                    end
                    osrt_pkg::MODE_RELEASE: begin
                        if (sid_ok) begin
                            n_owned[sid_idx] = 1'b0;
                            if (r_rel_head == sid_idx) n_state = osrt_pkg::ST_WALK;
                        end
                    end
                    osrt_pkg::MODE_OPEN: begin
                        if (r_writers != osrt_pkg::WRITERS_MAX) begin
                            n_writers = r_writers + osrt_pkg::WCNT_W'(1);
                        end
                    end
                    osrt_pkg::MODE_CLOSE: begin
                        if (r_writers <= osrt_pkg::WCNT_W'(1)) begin
                            n_writers = '0;
                            n_closed  = 1'b1;
                        end else begin
                            n_writers = r_writers - osrt_pkg::WCNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // One head step per cycle until the run ends
            osrt_pkg::ST_WALK: begin
                if (w_stat.stop) begin
                    n_state = osrt_pkg::ST_EMIT;
                end else begin
                    n_steps = r_steps + (IW + 1)'(1);
                    if (r_mode == osrt_pkg::MODE_MAKE) begin
                        n_ready_head = w_head_nx;
                        n_rcnt       = w_count_nx;
                    end else begin
                        n_rel_head = w_head_nx;
                        n_free     = w_count_nx;
                    end
                end
            end

            // Hand the result to the output register once it has room
            osrt_pkg::ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_closed, 4'(r_rcnt), 4'(r_free),
                                   4'(r_granted), r_status};
                    n_state     = osrt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = osrt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= osrt_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_owned      <= '0;
            r_ready      <= '0;
            r_put_head   <= '0;
            r_ready_head <= '0;
            r_take_head  <= '0;
            r_rel_head   <= '0;
            r_free       <= IW'(SLOTS - 1);
            r_rcnt       <= '0;
            r_closed     <= 1'b0;
            r_writers    <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_owned      <= n_owned;
            r_ready      <= n_ready;
            r_put_head   <= n_put_head;
            r_ready_head <= n_ready_head;
            r_take_head  <= n_take_head;
            r_rel_head   <= n_rel_head;
            r_free       <= n_free;
            r_rcnt       <= n_rcnt;
            r_closed     <= n_closed;
            r_writers    <= n_writers;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_sid      <= n_sid;
        r_status   <= n_status;
        r_granted  <= n_granted;
        r_steps    <= n_steps;
        r_out_data <= n_out_data;
    end

endmodule

[hw/rtl/osrt_walk_unit.sv]
// Shared ring step unit: head increment, credit increment and walk stop test.
// Used by put/take for head advance and by the head walk of make_available/release.
// Depends on osrt_pkg.
`timescale 1ns / 1ps

module osrt_walk_unit #(
    parameter int SLOTS = osrt_pkg::SLOTS_DEFAULT
) (
    input  logic [$clog2(SLOTS)-1:0] i_head,
    input  logic [$clog2(SLOTS)-1:0] i_limit,
    input  logic                     i_bit_ok,
    input  logic [$clog2(SLOTS)-1:0] i_count,
    input  logic [$clog2(SLOTS):0]   i_steps,
    output logic [$clog2(SLOTS)-1:0] o_head_nx,
    output logic [$clog2(SLOTS)-1:0] o_count_nx,
    output osrt_pkg::t_walk_stat     o_stat
);

    localparam int IW = $clog2(SLOTS);

    // Ring successor of the head
    assign o_head_nx = (i_head == IW'(SLOTS - 1)) ? '0 : i_head + IW'(1);

    // Saturating credit increment
    assign o_stat.sat  = (i_count == IW'(SLOTS - 1));
    assign o_count_nx  = o_stat.sat ? i_count : i_count + IW'(1);

    // Walk ends at a slot not yet done, at the bounding head, or after a full lap
    assign o_stat.stop = !i_bit_ok || (i_head == i_limit) || (i_steps == (IW + 1)'(SLOTS));

endmodule

[sim/tb_top.sv]
// Self-checking testbench for ordered_slot_ring_tracker_unit (commands in, results out).
// Holds its own model of the slot ring, a directed table, then random producer/consumer
// traffic. Depends on osrt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS = osrt_pkg::SLOTS_DEFAULT;
    localparam int HALF_PERIOD = 6;

    // Mode codes the block treats as no-ops
    localparam logic [osrt_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [osrt_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

    // One result, laid out as in m_axis_tdata[14:0]
    typedef struct packed {
        logic                          is_closed;
        logic [osrt_pkg::SLOT_W-1:0]   take_cr;
        logic [osrt_pkg::SLOT_W-1:0]   put_cr;
        logic [osrt_pkg::SLOT_W-1:0]   granted;
        logic [osrt_pkg::STATUS_W-1:0] status;
    } t_result;

    // Directed table row; want is used only when fixed is set
    typedef struct packed {
        logic [osrt_pkg::MODE_W-1:0] mode;
        logic [osrt_pkg::SID_W-1:0]  sid;
        logic                        fixed;
        t_result                     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [2:0] mode, [6:3] slot_id, [7] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [1:0] status, [5:2] granted_slot, [9:6] put_credits,
                                       // [13:10] take_credits, [14] is_closed, [15] zero

    ordered_slot_ring_tracker_unit #(.SLOTS(SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Model of the ring state
    bit owned_bits [SLOTS];
    bit ready_bits [SLOTS];
    int put_ptr;
    int ready_ptr;
    int take_ptr;
    int release_ptr;
    int free_cr;
    int ready_cr;
    bit q_closed;
    int writer_cnt;

    t_result result_q [$];
    t_row    dir_tab [$];
    int      prod_slots [$];  // granted to producers, not yet made available
    int      cons_slots [$];  // granted to consumers, not yet released

    int err_cnt = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int wait_cnt = 0;
    int closed_cnt = 0;
    int tx_idle = 31;
    int rx_idle = 31;

    function automatic int ring_succ(input int h);
        return (h + 1) % SLOTS;
    endfunction

    function automatic int credit_bump(input int c);
        return (c < SLOTS - 1) ? c + 1 : c;
    endfunction

    // Apply one command to the model and return the result it should produce
    function automatic t_result ring_apply(input logic [osrt_pkg::MODE_W-1:0] mode,
                                           input logic [osrt_pkg::SID_W-1:0] sid);
        t_result r;
        int      s;
        int      n;
        r = '0;
        s = int'(sid);
        case (mode)
            osrt_pkg::MODE_PUT: begin
                if (free_cr == 0) begin
                    r.status = osrt_pkg::STAT_WAIT;
                end else begin
                    r.granted = put_ptr[osrt_pkg::SLOT_W-1:0];
                    owned_bits[put_ptr] = 1'b1;
                    put_ptr = ring_succ(put_ptr);
                    free_cr--;
                end
            end
            osrt_pkg::MODE_MAKE: begin
                if (s < SLOTS) begin
                    ready_bits[s] = 1'b1;
                    // contiguous ready run from the head becomes take credit
                    if (ready_ptr == s) begin
                        for (n = 0; n < SLOTS; n++) begin
                            if (!ready_bits[ready_ptr] || ready_ptr == put_ptr) break;
                            ready_ptr = ring_succ(ready_ptr);
                            ready_cr = credit_bump(ready_cr);
                        end
                    end
                end
            end
            osrt_pkg::MODE_TAKE: begin
                if (ready_cr == 0) begin
                    r.status = q_closed ? osrt_pkg::STAT_CLOSED : osrt_pkg::STAT_WAIT;
                end else begin
                    r.granted = take_ptr[osrt_pkg::SLOT_W-1:0];
                    ready_bits[take_ptr] = 1'b0;
                    take_ptr = ring_succ(take_ptr);
                    ready_cr--;
                end
            end
            osrt_pkg::MODE_RELEASE: begin
                if (s < SLOTS) begin
                    owned_bits[s] = 1'b0;
                    // contiguous freed run from the head becomes put credit
                    if (release_ptr == s) begin
                        for (n = 0; n < SLOTS; n++) begin
                            if (owned_bits[release_ptr] || release_ptr == take_ptr) break;
                            release_ptr = ring_succ(release_ptr);
                            free_cr = credit_bump(free_cr);
                        end
                    end
                end
            end
            osrt_pkg::MODE_OPEN: begin
                if (writer_cnt < int'(osrt_pkg::WRITERS_MAX)) writer_cnt++;
            end
            osrt_pkg::MODE_CLOSE: begin
                if (writer_cnt <= 1) begin
                    writer_cnt = 0;
                    q_closed = 1'b1;
                end else begin
                    writer_cnt--;
                end
            end
            default: ;
        endcase
        r.put_cr = free_cr[osrt_pkg::SLOT_W-1:0];
        r.take_cr = ready_cr[osrt_pkg::SLOT_W-1:0];
        r.is_closed = q_closed;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Result checker: oldest expectation against each transaction on the master side
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[14:0];
            if (result_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = result_q.pop_front();
                check_field("status", int'(want.status), int'(got.status));
                check_field("granted_slot", int'(want.granted), int'(got.granted));
                check_field("put_credits", int'(want.put_cr), int'(got.put_cr));
                check_field("take_credits", int'(want.take_cr), int'(got.take_cr));
                check_field("is_closed", int'(want.is_closed), int'(got.is_closed));
                checked_cnt++;
                if (got.status == osrt_pkg::STAT_WAIT) wait_cnt++;
                if (got.status == osrt_pkg::STAT_CLOSED) closed_cnt++;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Drive one command; the model is stepped at the accepting edge
    task automatic send_cmd(input logic [osrt_pkg::MODE_W-1:0] mode,
                            input logic [osrt_pkg::SID_W-1:0] sid,
                            input logic fixed, input t_result want, output t_result pred);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, sid, mode};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = ring_apply(mode, sid);
        result_q.push_back(fixed ? want : pred);
        sent_cnt++;
    endtask

    task automatic add_row(input logic [osrt_pkg::MODE_W-1:0] mode,
                           input logic [osrt_pkg::SID_W-1:0] sid,
                           input logic fixed, input logic [osrt_pkg::STATUS_W-1:0] st,
                           input int granted, input int putc, input int takec,
                           input logic closed);
        t_row row;
        row.mode = mode;
        row.sid = sid;
        row.fixed = fixed;
        row.want.status = st;
        row.want.granted = granted[osrt_pkg::SLOT_W-1:0];
        row.want.put_cr = putc[osrt_pkg::SLOT_W-1:0];
        row.want.take_cr = takec[osrt_pkg::SLOT_W-1:0];
        row.want.is_closed = closed;
        dir_tab.push_back(row);
    endtask

    // One random command of producer/consumer traffic, skewed by the epoch weights
    task automatic traffic_cmd(input int w_put, input int w_take, input bit may_close);
        logic [osrt_pkg::MODE_W-1:0] mode;
        logic [osrt_pkg::SID_W-1:0]  sid;
        t_result                     pred;
        int                          pick;
        int                          idx;
        sid = osrt_pkg::SID_W'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 6) begin
            mode = osrt_pkg::MODE_W'($urandom_range(7));
        end else begin
            pick = $urandom_range(99);
            if (pick < w_put) begin
                mode = osrt_pkg::MODE_PUT;
            end else if (pick < 50) begin
                mode = osrt_pkg::MODE_MAKE;
                if (prod_slots.size() != 0) begin
                    idx = $urandom_range(prod_slots.size() - 1);
                    sid = osrt_pkg::SID_W'(prod_slots[idx]);
                    prod_slots.delete(idx);
                end
            end else if (pick < 50 + w_take) begin
                mode = osrt_pkg::MODE_TAKE;
            end else if (pick < 97) begin
                mode = osrt_pkg::MODE_RELEASE;
                if (cons_slots.size() != 0) begin
                    idx = $urandom_range(cons_slots.size() - 1);
                    sid = osrt_pkg::SID_W'(cons_slots[idx]);
                    cons_slots.delete(idx);
                end
            end else if (may_close && $urandom_range(1) == 1) begin
                mode = osrt_pkg::MODE_CLOSE;
            end else begin
                mode = osrt_pkg::MODE_OPEN;
            end
        end
        // keep at least one writer while the queue is meant to stay open
        if (mode == osrt_pkg::MODE_CLOSE && !may_close && writer_cnt <= 1) begin
            mode = osrt_pkg::MODE_OPEN;
        end
        send_cmd(mode, sid, 1'b0, '0, pred);
        if (pred.status == osrt_pkg::STAT_DONE && mode == osrt_pkg::MODE_PUT) begin
            prod_slots.push_back(int'(pred.granted));
        end
        if (pred.status == osrt_pkg::STAT_DONE && mode == osrt_pkg::MODE_TAKE) begin
            cons_slots.push_back(int'(pred.granted));
        end
    endtask

    // Random traffic in epochs of varying producer/consumer balance
    task automatic traffic_phase(input int count, input bit may_close, input int calm_lo,
                                 input int calm_hi);
        int w_put;
        int w_take;
        int i;
        w_put = 30;
        w_take = 30;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                w_put = $urandom_range(45, 10);
                w_take = $urandom_range(45, 10);
            end
            if (i == calm_lo) begin
                tx_idle = 0;
                rx_idle <= 0;
            end
            if (i == calm_hi) begin
                tx_idle = 31;
                rx_idle <= 31;
            end
            traffic_cmd(w_put, w_take, may_close);
        end
    endtask

    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin : stimulus
        t_result pred;
        int      i;
        for (i = 0; i < SLOTS; i++) begin
            owned_bits[i] = 1'b0;
            ready_bits[i] = 1'b0;
        end
        put_ptr = 0;
        ready_ptr = 0;
        take_ptr = 0;
        release_ptr = 0;
        free_cr = SLOTS - 1;
        ready_cr = 0;
        q_closed = 1'b0;
        writer_cnt = 0;

        // take on empty open queue, puts, out-of-order make, head walks, no-op modes, writers
        add_row(osrt_pkg::MODE_TAKE,    4'd0,  1'b1, osrt_pkg::STAT_WAIT, 0, 15, 0, 1'b0);
        add_row(osrt_pkg::MODE_PUT,     4'd15, 1'b1, osrt_pkg::STAT_DONE, 0, 14, 0, 1'b0);
        add_row(osrt_pkg::MODE_PUT,     4'd0,  1'b1, osrt_pkg::STAT_DONE, 1, 13, 0, 1'b0);
        add_row(osrt_pkg::MODE_MAKE,    4'd1,  1'b1, osrt_pkg::STAT_DONE, 0, 13, 0, 1'b0);
        add_row(osrt_pkg::MODE_MAKE,    4'd0,  1'b1, osrt_pkg::STAT_DONE, 0, 13, 2, 1'b0);
        add_row(osrt_pkg::MODE_TAKE,    4'd15, 1'b1, osrt_pkg::STAT_DONE, 0, 13, 1, 1'b0);
        add_row(osrt_pkg::MODE_TAKE,    4'd0,  1'b1, osrt_pkg::STAT_DONE, 1, 13, 0, 1'b0);
        add_row(osrt_pkg::MODE_RELEASE, 4'd1,  1'b1, osrt_pkg::STAT_DONE, 0, 13, 0, 1'b0);
        add_row(osrt_pkg::MODE_RELEASE, 4'd0,  1'b1, osrt_pkg::STAT_DONE, 0, 15, 0, 1'b0);
        add_row(osrt_pkg::MODE_MAKE,    4'd15, 1'b1, osrt_pkg::STAT_DONE, 0, 15, 0, 1'b0);
        add_row(osrt_pkg::MODE_RELEASE, 4'd15, 1'b0, osrt_pkg::STAT_DONE, 0, 0, 0, 1'b0);
        add_row(MODE_SPARE6,            4'd10, 1'b1, osrt_pkg::STAT_DONE, 0, 15, 0, 1'b0);
        add_row(MODE_SPARE7,            4'd5,  1'b1, osrt_pkg::STAT_DONE, 0, 15, 0, 1'b0);
        add_row(osrt_pkg::MODE_OPEN,    4'd0,  1'b1, osrt_pkg::STAT_DONE, 0, 15, 0, 1'b0);
        add_row(osrt_pkg::MODE_OPEN,    4'd9,  1'b0, osrt_pkg::STAT_DONE, 0, 0, 0, 1'b0);
        add_row(osrt_pkg::MODE_CLOSE,   4'd6,  1'b1, osrt_pkg::STAT_DONE, 0, 15, 0, 1'b0);
        add_row(osrt_pkg::MODE_PUT,     4'd7,  1'b0, osrt_pkg::STAT_DONE, 0, 0, 0, 1'b0);
        add_row(osrt_pkg::MODE_MAKE,    4'd2,  1'b0, osrt_pkg::STAT_DONE, 0, 0, 0, 1'b0);
        add_row(osrt_pkg::MODE_TAKE,    4'd3,  1'b0, osrt_pkg::STAT_DONE, 0, 0, 0, 1'b0);
        add_row(osrt_pkg::MODE_PUT,     4'd12, 1'b0, osrt_pkg::STAT_DONE, 0, 0, 0, 1'b0);
        add_row(osrt_pkg::MODE_TAKE,    4'd0,  1'b1, osrt_pkg::STAT_WAIT, 0, 13, 0, 1'b0);
        add_row(osrt_pkg::MODE_RELEASE, 4'd2,  1'b0, osrt_pkg::STAT_DONE, 0, 0, 0, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_cmd(dir_tab[i].mode, dir_tab[i].sid, dir_tab[i].fixed, dir_tab[i].want, pred);
            // the last put hands out slot 3 to a producer that makes it available later
            if (dir_tab[i].mode == osrt_pkg::MODE_PUT && pred.status == osrt_pkg::STAT_DONE
                && i > 16) begin
                prod_slots.push_back(int'(pred.granted));
            end
        end

        // open queue: mixed traffic, with a stretch of full-rate handshakes
        traffic_phase(550, 1'b0, 200, 350);

        // writer count to its ceiling, pause until idle, then close the queue for good
        for (i = 0; i < 258; i++) begin
            send_cmd(osrt_pkg::MODE_OPEN, osrt_pkg::SID_W'($urandom_range(15)), 1'b0, '0,
                     pred);
        end
        drain_results();
        for (i = 0; i < 258; i++) begin
            send_cmd(osrt_pkg::MODE_CLOSE, osrt_pkg::SID_W'($urandom_range(15)), 1'b0, '0,
                     pred);
        end
        send_cmd(osrt_pkg::MODE_OPEN, 4'd0, 1'b0, '0, pred);

        // closed queue: takes on empty report closed
        traffic_phase(320, 1'b1, -1, -1);

        drain_results();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (result_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d results never arrived, expected 0, actual %0d", $time,
                     result_q.size(), result_q.size());
        end

        $display("Ran %0d commands, %0d results checked (%0d wait, %0d closed-empty);",
                 sent_cnt, checked_cnt, wait_cnt, closed_cnt);
        $display("covered credit exhaustion, out-of-order completion, writer bounds, closure.");
        if (err_cnt == 0) begin
            $display("PASS ordered_slot_ring_tracker_unit");
        end else begin
            $display("FAIL ordered_slot_ring_tracker_unit");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #10_000_000;
        $display("FAIL ordered_slot_ring_tracker_unit");
        $finish;
    end

endmodule
